// ===== rtl/sfcc_pkg.sv =====
package sfcc_pkg;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // Byte positions within one six-byte reply.
  localparam logic [2:0] POS_A_HI  = 3'd0;
  localparam logic [2:0] POS_A_LO  = 3'd1;
  localparam logic [2:0] POS_A_CRC = 3'd2;
  localparam logic [2:0] POS_B_HI  = 3'd3;
  localparam logic [2:0] POS_B_LO  = 3'd4;
  localparam logic [2:0] POS_B_CRC = 3'd5;

  localparam logic        MODE_MEASURE = 1'b0;
  localparam logic        MODE_SERIAL  = 1'b1;

  localparam logic [14:0] TEMP_SCALE  = 15'd17500;
  localparam logic [13:0] HUM_SCALE   = 14'd12500;
  localparam logic [15:0] TEMP_OFFSET = 16'd4500;
  localparam logic [14:0] HUM_OFFSET  = 15'd600;
  localparam logic [14:0] HUM_MAX     = 15'd10000;
  localparam logic [16:0] WORD_MAX    = 17'd65535;

  // One completed reply as handed from the front end to the back end.
  typedef struct packed {
    logic [15:0] first_word;
    logic [15:0] second_word;
    logic        crc_failed;
    logic        reply_mode;
  } frame_t;

  // CRC-8, MSB first, one byte per call.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/sfcc_front.sv =====
module sfcc_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [7:0]           rx_byte_i,
  input  logic                 frame_start_i,
  input  logic                 reply_mode_we_i,
  input  logic                 reply_mode_i,
  output logic                 push_o,
  output sfcc_pkg::frame_t     frame_o
);

  logic [2:0]  pos_q, pos_d, pos;
  logic [7:0]  crc_q, crc_d, crc_seed, crc_next;
  logic [15:0] first_q, first_d;
  logic [15:0] second_q, second_d;
  logic        failed_q, failed_d;
  logic        mode_q;
  logic        crc_bad;

  always_comb begin
    pos = frame_start_i ? sfcc_pkg::POS_A_HI : pos_q;
    if (pos > sfcc_pkg::POS_B_CRC) begin
      pos = sfcc_pkg::POS_A_HI;
    end
  end

  // The CRC restarts at the high byte of each word.
  assign crc_seed = (pos == sfcc_pkg::POS_A_HI || pos == sfcc_pkg::POS_B_HI) ?
                    sfcc_pkg::CRC_INIT : crc_q;
  assign crc_next = sfcc_pkg::crc8_byte(crc_seed, rx_byte_i);
  assign crc_bad  = (crc_q != rx_byte_i);

  always_comb begin
    pos_d    = pos_q;
    crc_d    = crc_q;
    first_d  = first_q;
    second_d = second_q;
    failed_d = failed_q;
    if (accept_i) begin
      unique case (pos)
        sfcc_pkg::POS_A_HI: begin
          failed_d = 1'b0;
          crc_d    = crc_next;
          first_d  = {rx_byte_i, 8'h00};
        end
        sfcc_pkg::POS_A_LO: begin
          crc_d   = crc_next;
          first_d = {first_q[15:8], rx_byte_i};
        end
        sfcc_pkg::POS_B_HI: begin
          crc_d    = crc_next;
          second_d = {rx_byte_i, 8'h00};
        end
        sfcc_pkg::POS_B_LO: begin
          crc_d    = crc_next;
          second_d = {second_q[15:8], rx_byte_i};
        end
        default: begin
          if (crc_bad) begin
            failed_d = 1'b1;
          end
        end
      endcase
      pos_d = (pos == sfcc_pkg::POS_B_CRC) ? sfcc_pkg::POS_A_HI : pos + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= sfcc_pkg::POS_A_HI;
      crc_q    <= sfcc_pkg::CRC_INIT;
      failed_q <= 1'b0;
      mode_q   <= sfcc_pkg::MODE_MEASURE;
    end else begin
      pos_q    <= pos_d;
      crc_q    <= crc_d;
      failed_q <= failed_d;
      if (reply_mode_we_i) begin
        mode_q <= reply_mode_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    first_q  <= first_d;
    second_q <= second_d;
  end

  assign push_o               = accept_i && (pos == sfcc_pkg::POS_B_CRC);
  assign frame_o.first_word   = first_q;
  assign frame_o.second_word  = second_q;
  assign frame_o.crc_failed   = failed_q | crc_bad;
  assign frame_o.reply_mode   = mode_q;

endmodule

// ===== rtl/sfcc_fifo.sv =====
module sfcc_fifo #(
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sfcc_pkg::frame_t data_i,
  output logic             full_o,
  output logic             valid_o,
  output sfcc_pkg::frame_t data_o,
  input  logic             pop_i
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  sfcc_pkg::frame_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/sfcc_back.sv =====
module sfcc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               frame_valid_i,
  input  sfcc_pkg::frame_t   frame_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [14:0] temperature_centi_o,
  output logic [13:0]        humidity_centi_o,
  output logic [31:0]        serial_number_o,
  output logic               status_o
);

  // floor(p / 65535) for p below 65535 * 65536: p = q0 * 65535 + (q0 + lo),
  // and q0 + lo stays below twice the divisor.
  function automatic logic [14:0] div_word_max(input logic [30:0] p);
    logic [14:0] q0;
    logic [16:0] rem;
    q0  = p[30:16];
    rem = {2'b00, q0} + {1'b0, p[15:0]};
    return q0 + ((rem >= sfcc_pkg::WORD_MAX) ? 15'd1 : 15'd0);
  endfunction

  // Stage 1: products.
  logic        s1_valid_q;
  logic [30:0] s1_temp_q;
  logic [29:0] s1_hum_q;
  logic [31:0] s1_serial_q;
  logic        s1_failed_q, s1_mode_q;

  logic        s2_en, s1_load;
  logic [30:0] temp_prod;
  logic [29:0] hum_prod;

  // Output registers.
  logic               out_valid_q;
  logic signed [14:0] temp_q;
  logic [13:0]        hum_q;
  logic [31:0]        serial_q;
  logic               status_q;

  assign s2_en   = !out_valid_q || out_ready_i;
  assign s1_load = !s1_valid_q || s2_en;
  assign pop_o   = s1_load && frame_valid_i;

  assign temp_prod = {15'd0, frame_i.first_word} * {16'd0, sfcc_pkg::TEMP_SCALE};
  assign hum_prod  = {14'd0, frame_i.second_word} * {16'd0, sfcc_pkg::HUM_SCALE};

  // Stage 2: scale, offset and saturation.
  logic [14:0]        q_temp, q_hum, hum_sub;
  logic [15:0]        temp_wide;
  logic signed [14:0] temp_d;
  logic [13:0]        hum_d;
  logic [31:0]        serial_d;
  logic               meas_ok, serial_ok;

  assign q_temp    = div_word_max(s1_temp_q);
  assign q_hum     = div_word_max({1'b0, s1_hum_q});
  assign temp_wide = {1'b0, q_temp} - sfcc_pkg::TEMP_OFFSET;
  assign hum_sub   = q_hum - sfcc_pkg::HUM_OFFSET;
  assign meas_ok   = !s1_failed_q && (s1_mode_q == sfcc_pkg::MODE_MEASURE);
  assign serial_ok = !s1_failed_q && (s1_mode_q == sfcc_pkg::MODE_SERIAL);

  always_comb begin
    temp_d   = meas_ok ? $signed(temp_wide[14:0]) : 15'sd0;
    hum_d    = '0;
    serial_d = serial_ok ? s1_serial_q : '0;
    if (meas_ok && q_hum >= sfcc_pkg::HUM_OFFSET) begin
      hum_d = (hum_sub > sfcc_pkg::HUM_MAX) ? sfcc_pkg::HUM_MAX[13:0] : hum_sub[13:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_q <= frame_valid_i;
      end
      if (s2_en) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_temp_q   <= temp_prod;
      s1_hum_q    <= hum_prod;
      s1_serial_q <= {frame_i.first_word, frame_i.second_word};
      s1_failed_q <= frame_i.crc_failed;
      s1_mode_q   <= frame_i.reply_mode;
    end
    if (s2_en && s1_valid_q) begin
      temp_q   <= temp_d;
      hum_q    <= hum_d;
      serial_q <= serial_d;
      status_q <= s1_failed_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign temperature_centi_o = temp_q;
  assign humidity_centi_o    = hum_q;
  assign serial_number_o     = serial_q;
  assign status_o            = status_q;

endmodule

// ===== rtl/sensor_frame_crc_convert_core.sv =====
// Sensor reply checker and converter. Bytes arrive on the input channel one
// transfer each, up to one per cycle; a reply is six bytes (word A, its CRC-8,
// word B, its CRC-8, polynomial 0x31 seeded with 0xFF per word), and frame_start_i
// on a byte restarts the reply there, dropping any partial one. The sixth byte
// yields one result: temperature and humidity in hundredths in measure mode, or
// the 32-bit serial number in serial mode, with status_o set and all value fields
// zero on a CRC mismatch. The CRC is unrolled, so the front end takes a byte every
// cycle; completed replies wait in a QueueDepth-entry queue ahead of a two-stage
// multiply and scale pipeline, so the input stalls only when that queue is full
// while results are held at the output. The user must write reply_mode_i with
// reply_mode_we_i only while the block is idle; the block does not enforce this.
module sensor_frame_crc_convert_core #(
  parameter int QueueDepth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  input  logic               frame_start_i,
  input  logic               reply_mode_we_i,
  input  logic               reply_mode_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [14:0] temperature_centi_o,
  output logic [13:0]        humidity_centi_o,
  output logic [31:0]        serial_number_o,
  output logic               status_o
);

  sfcc_pkg::frame_t push_frame, head_frame;
  logic             push, full, head_valid, pop, accept;

  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;

  sfcc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .rx_byte_i       (rx_byte_i),
    .frame_start_i   (frame_start_i),
    .reply_mode_we_i (reply_mode_we_i),
    .reply_mode_i    (reply_mode_i),
    .push_o          (push),
    .frame_o         (push_frame)
  );

  sfcc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_frame),
    .full_o  (full),
    .valid_o (head_valid),
    .data_o  (head_frame),
    .pop_i   (pop)
  );

  sfcc_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .frame_valid_i       (head_valid),
    .frame_i             (head_frame),
    .pop_o               (pop),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .temperature_centi_o (temperature_centi_o),
    .humidity_centi_o    (humidity_centi_o),
    .serial_number_o     (serial_number_o),
    .status_o            (status_o)
  );

endmodule

// ===== rtl/sfcc_checker.sv =====
module sfcc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [7:0]         rx_byte_i,
  input logic               frame_start_i,
  input logic               reply_mode_we_i,
  input logic               reply_mode_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [14:0] temperature_centi_o,
  input logic [13:0]        humidity_centi_o,
  input logic [31:0]        serial_number_o,
  input logic               status_o
);

  // A stalled result holds its values until the transfer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(temperature_centi_o) &&
    $stable(humidity_centi_o) && $stable(serial_number_o) && $stable(status_o))
    else $error("result changed while stalled");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |->
    temperature_centi_o == 15'sd0 && humidity_centi_o == 14'd0 && serial_number_o == 32'd0)
    else $error("CRC error result carries values");

  a_ranges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> humidity_centi_o <= 14'd10000 &&
    temperature_centi_o >= -15'sd4500 && temperature_centi_o <= 15'sd13000)
    else $error("converted value out of range");

  a_mode_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && serial_number_o != 32'd0 |->
    temperature_centi_o == 15'sd0 && humidity_centi_o == 14'd0)
    else $error("serial and measurement fields both set");

  // The queue only fills up when results are being held back at the output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no pending result");

endmodule

bind sensor_frame_crc_convert_core sfcc_checker u_sfcc_checker (.*);
